// ===== hw/rtl/pac_pkg.sv =====
// Shared types and constants of the polygon acceptance check.
package pac_pkg;

   localparam int COORD_WIDTH        = 32;
   localparam int Z_WIDTH            = 32;
   localparam int CORNER_INDEX_WIDTH = 4;
   localparam int COUNT_WIDTH        = 5;
   localparam int RADIUS_WIDTH       = 31;
   localparam int CSR_INDEX_WIDTH    = 2;
   localparam int CSR_DATA_WIDTH     = 32;
   localparam int NUM_PLANES         = 2;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_CORNER_COUNT = 2'd0,
      CSR_HOLE_RADIUS  = 2'd1,
      CSR_FRONT_Z      = 2'd2,
      CSR_MIN_DECAY_Z  = 2'd3
   } csr_index_type;

   typedef enum logic {
      ACTION_TEST = 1'b0,
      ACTION_LOAD = 1'b1
   } action_type;

   typedef struct packed {
      action_type                      action;
      logic [CORNER_INDEX_WIDTH-1:0]   corner_index;
      logic signed [COORD_WIDTH-1:0]   corner_x;
      logic signed [COORD_WIDTH-1:0]   corner_y;
      logic signed [COORD_WIDTH-1:0]   front_x;
      logic signed [COORD_WIDTH-1:0]   front_y;
      logic signed [COORD_WIDTH-1:0]   back_x;
      logic signed [COORD_WIDTH-1:0]   back_y;
      logic signed [Z_WIDTH-1:0]       production_z;
      logic signed [Z_WIDTH-1:0]       decay_z;
   } req_type;

   typedef struct packed {
      logic accepted;
      logic inside_front;
      logic inside_back;
      logic in_hole;
   } rsp_type;

endpackage

// ===== hw/rtl/polygon_acceptance_check.sv =====
// A test beat passes through stage 1, the multiplier stages, stage 4 and the result register.
// Throughput: one beat per cycle; a load beat writes a corner and gives no result.
// Every polygon edge on both planes has its own multipliers, so the rate does
// not depend on the corner count; the whole pipeline holds while the result stalls.
// Reset clears the valid bits and the configuration registers; the corner table
// is not cleared and must be loaded before use.
module polygon_acceptance_check #(
   parameter int MAX_CORNERS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  pac_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output pac_pkg::rsp_type                    rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  pac_pkg::csr_index_type              csr_index,
   input  logic [pac_pkg::CSR_DATA_WIDTH-1:0]  csr_data
);

   localparam int CW     = pac_pkg::COORD_WIDTH;
   localparam int OW     = CW + 1;
   localparam int PW     = 2 * OW;
   localparam int NP     = pac_pkg::NUM_PLANES;
   localparam int RW     = pac_pkg::RADIUS_WIDTH;
   localparam int IW     = (MAX_CORNERS > 1) ? $clog2(MAX_CORNERS) : 1;
   localparam int CNT_W  = $clog2(MAX_CORNERS + 1);
   localparam int CMPN   = (CNT_W > pac_pkg::COUNT_WIDTH) ? CNT_W : pac_pkg::COUNT_WIDTH;
   localparam int CMPI   = (IW > pac_pkg::CORNER_INDEX_WIDTH) ? IW
                                                              : pac_pkg::CORNER_INDEX_WIDTH;
   localparam int HOLE_W = (PW > 2 * RW) ? PW : 2 * RW;

   // Configuration registers.
   logic [pac_pkg::COUNT_WIDTH-1:0]     corner_count_ff;
   logic [RW-1:0]                       hole_radius_ff;
   logic signed [pac_pkg::Z_WIDTH-1:0]  front_z_ff;
   logic signed [pac_pkg::Z_WIDTH-1:0]  min_decay_z_ff;
   logic [2*RW-1:0]                     radius_sq_ff;

   // Corner table.
   logic signed [CW-1:0]  corner_x_ff [MAX_CORNERS];
   logic signed [CW-1:0]  corner_y_ff [MAX_CORNERS];

   logic                  advance;
   logic                  load_beat;
   logic [CMPN-1:0]       n_eff;
   logic [CMPN-1:0]       n_minus1;
   logic [IW-1:0]         last_idx;
   logic signed [CW-1:0]  wrap_x, wrap_y;
   logic signed [CW-1:0]  edge_xj [MAX_CORNERS];
   logic signed [CW-1:0]  edge_yj [MAX_CORNERS];
   logic [MAX_CORNERS-1:0] active;
   logic signed [CW-1:0]  pt_x [NP];
   logic signed [CW-1:0]  pt_y [NP];
   logic [MAX_CORNERS-1:0] edge_live [NP];
   logic [MAX_CORNERS-1:0] edge_up [NP];

   // Stage 1: differences and edge flags.
   logic                  s1_valid_ff;
   logic                  s1_cut_ok_ff;
   logic signed [OW-1:0]  s1_px_ff [NP];
   logic signed [OW-1:0]  s1_py_ff [NP];
   logic signed [OW-1:0]  s1_a_ff  [NP][MAX_CORNERS];
   logic signed [OW-1:0]  s1_b_ff  [NP][MAX_CORNERS];
   logic signed [OW-1:0]  s1_c_ff  [NP][MAX_CORNERS];
   logic signed [OW-1:0]  s1_dy_ff [NP][MAX_CORNERS];
   logic [MAX_CORNERS-1:0] s1_live_ff [NP];
   logic [MAX_CORNERS-1:0] s1_up_ff [NP];

   // Stages 2 and 3 run inside the multipliers; flags travel alongside.
   logic                  s2_valid_ff, s3_valid_ff;
   logic                  s2_cut_ok_ff, s3_cut_ok_ff;
   logic [MAX_CORNERS-1:0] s2_live_ff [NP];
   logic [MAX_CORNERS-1:0] s3_live_ff [NP];
   logic [MAX_CORNERS-1:0] s2_up_ff [NP];
   logic [MAX_CORNERS-1:0] s3_up_ff [NP];

   logic signed [PW-1:0]  prod_ab [NP][MAX_CORNERS];
   logic signed [PW-1:0]  prod_cd [NP][MAX_CORNERS];
   logic signed [PW-1:0]  sq_x [NP];
   logic signed [PW-1:0]  sq_y [NP];

   // Stage 4: crossing bits and hole test per plane.
   logic                  s4_valid_ff;
   logic                  s4_cut_ok_ff;
   logic [MAX_CORNERS-1:0] s4_cross_in [NP];
   logic [MAX_CORNERS-1:0] s4_cross_ff [NP];
   logic [PW-1:0]         sq_sum [NP];
   logic [NP-1:0]         s4_near_in, s4_near_ff;

   // Stage 5: result register.
   logic                  rsp_valid_ff;
   pac_pkg::rsp_type      rsp_data_in, rsp_data_ff;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;
   assign load_beat = req_valid && advance && (req_data.action == pac_pkg::ACTION_LOAD);
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         corner_count_ff <= '0;
         hole_radius_ff  <= '0;
         front_z_ff      <= '0;
         min_decay_z_ff  <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            pac_pkg::CSR_CORNER_COUNT: begin
               corner_count_ff <= csr_data[pac_pkg::COUNT_WIDTH-1:0];
            end
            pac_pkg::CSR_HOLE_RADIUS: begin
               hole_radius_ff <= csr_data[RW-1:0];
            end
            pac_pkg::CSR_FRONT_Z: begin
               front_z_ff <= $signed(csr_data[pac_pkg::Z_WIDTH-1:0]);
            end
            pac_pkg::CSR_MIN_DECAY_Z: begin
               min_decay_z_ff <= $signed(csr_data[pac_pkg::Z_WIDTH-1:0]);
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      radius_sq_ff <= hole_radius_ff * hole_radius_ff;
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < MAX_CORNERS; k++) begin
         if (load_beat && (CMPI'(req_data.corner_index) == CMPI'(k))) begin
            corner_x_ff[k] <= req_data.corner_x;
            corner_y_ff[k] <= req_data.corner_y;
         end
      end
   end

   // The closing edge runs from corner zero back to the last corner in use.
   assign n_eff = (CMPN'(corner_count_ff) > CMPN'(MAX_CORNERS)) ? CMPN'(MAX_CORNERS)
                                                                : CMPN'(corner_count_ff);
   assign n_minus1 = n_eff - CMPN'(1);
   assign last_idx = n_minus1[IW-1:0];
   assign wrap_x   = corner_x_ff[last_idx];
   assign wrap_y   = corner_y_ff[last_idx];

   assign pt_x[0] = req_data.front_x;
   assign pt_y[0] = req_data.front_y;
   assign pt_x[1] = req_data.back_x;
   assign pt_y[1] = req_data.back_y;

   always_comb begin
      edge_xj[0] = wrap_x;
      edge_yj[0] = wrap_y;
      for (int k = 1; k < MAX_CORNERS; k++) begin
         edge_xj[k] = corner_x_ff[k-1];
         edge_yj[k] = corner_y_ff[k-1];
      end
   end

   always_comb begin
      for (int k = 0; k < MAX_CORNERS; k++) begin
         active[k] = CMPN'(k) < n_eff;
      end
      for (int p = 0; p < NP; p++) begin
         for (int k = 0; k < MAX_CORNERS; k++) begin
            edge_live[p][k] = active[k]
               && (((corner_y_ff[k] < pt_y[p]) && (edge_yj[k] >= pt_y[p]))
                  || ((edge_yj[k] < pt_y[p]) && (corner_y_ff[k] >= pt_y[p])));
            edge_up[p][k] = edge_yj[k] > corner_y_ff[k];
         end
      end
   end

   // Valid bits of the pipeline.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= req_valid && (req_data.action == pac_pkg::ACTION_TEST);
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         rsp_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_cut_ok_ff <= !(req_data.decay_z < min_decay_z_ff)
                      && !(req_data.production_z > front_z_ff);
         for (int p = 0; p < NP; p++) begin
            s1_px_ff[p]   <= OW'(pt_x[p]);
            s1_py_ff[p]   <= OW'(pt_y[p]);
            s1_live_ff[p] <= edge_live[p];
            s1_up_ff[p]   <= edge_up[p];
            for (int k = 0; k < MAX_CORNERS; k++) begin
               s1_a_ff[p][k]  <= OW'(pt_y[p]) - OW'(corner_y_ff[k]);
               s1_b_ff[p][k]  <= OW'(edge_xj[k]) - OW'(corner_x_ff[k]);
               s1_c_ff[p][k]  <= OW'(pt_x[p]) - OW'(corner_x_ff[k]);
               s1_dy_ff[p][k] <= OW'(edge_yj[k]) - OW'(corner_y_ff[k]);
            end
         end
         s2_cut_ok_ff <= s1_cut_ok_ff;
         s3_cut_ok_ff <= s2_cut_ok_ff;
         s4_cut_ok_ff <= s3_cut_ok_ff;
         for (int p = 0; p < NP; p++) begin
            s2_live_ff[p]  <= s1_live_ff[p];
            s3_live_ff[p]  <= s2_live_ff[p];
            s2_up_ff[p]    <= s1_up_ff[p];
            s3_up_ff[p]    <= s2_up_ff[p];
            s4_cross_ff[p] <= s4_cross_in[p];
         end
         s4_near_ff  <= s4_near_in;
         rsp_data_ff <= rsp_data_in;
      end
   end

   for (genvar p = 0; p < NP; p++) begin : g_plane
      for (genvar k = 0; k < MAX_CORNERS; k++) begin : g_edge
         pac_mul #(.WIDTH(OW)) u_mul_ab (
            .clock   (clock),
            .enable  (advance),
            .mul_a   (s1_a_ff[p][k]),
            .mul_b   (s1_b_ff[p][k]),
            .product (prod_ab[p][k])
         );
         pac_mul #(.WIDTH(OW)) u_mul_cd (
            .clock   (clock),
            .enable  (advance),
            .mul_a   (s1_c_ff[p][k]),
            .mul_b   (s1_dy_ff[p][k]),
            .product (prod_cd[p][k])
         );
      end
      pac_mul #(.WIDTH(OW)) u_sq_x (
         .clock   (clock),
         .enable  (advance),
         .mul_a   (s1_px_ff[p]),
         .mul_b   (s1_px_ff[p]),
         .product (sq_x[p])
      );
      pac_mul #(.WIDTH(OW)) u_sq_y (
         .clock   (clock),
         .enable  (advance),
         .mul_a   (s1_py_ff[p]),
         .mul_b   (s1_py_ff[p]),
         .product (sq_y[p])
      );
   end

   // The crossing x lies left of the point when (y-yi)*(xj-xi) and (x-xi)*dy
   // compare in the order that the sign of dy gives.
   always_comb begin
      for (int p = 0; p < NP; p++) begin
         for (int k = 0; k < MAX_CORNERS; k++) begin
            s4_cross_in[p][k] = s3_live_ff[p][k]
               && (s3_up_ff[p][k] ? (prod_ab[p][k] < prod_cd[p][k])
                                  : (prod_cd[p][k] < prod_ab[p][k]));
         end
         // Both squares are below 2**(2*CW), so their sum fits in PW bits.
         sq_sum[p]     = $unsigned(sq_x[p]) + $unsigned(sq_y[p]);
         s4_near_in[p] = HOLE_W'(sq_sum[p]) < HOLE_W'(radius_sq_ff);
      end
   end

   always_comb begin
      rsp_data_in.inside_front = ^s4_cross_ff[0];
      rsp_data_in.inside_back  = ^s4_cross_ff[1];
      rsp_data_in.in_hole      = &s4_near_ff;
      rsp_data_in.accepted     = rsp_data_in.inside_front && rsp_data_in.inside_back
                              && !rsp_data_in.in_hole && s4_cut_ok_ff;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_load_no_result: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && (req_data.action == pac_pkg::ACTION_LOAD)) |=> !s1_valid_ff)
      else $error("load beat entered the test pipeline");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (s4_valid_ff && advance) |=> rsp_valid_ff)
      else $error("test beat lost between last stage and result register");

   a_accept_consistent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!rsp_data_ff.accepted
         || (rsp_data_ff.inside_front && rsp_data_ff.inside_back && !rsp_data_ff.in_hole)))
      else $error("accepted flag disagrees with inside and hole flags");

   a_stall_holds_pipe: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> ($stable(s1_valid_ff) && $stable(s4_valid_ff)))
      else $error("pipeline moved while the result was stalled");

endmodule

// ===== hw/rtl/pac_mul.sv =====
// Two-stage signed multiplier built from four registered partial products.
module pac_mul #(
   parameter int WIDTH = 33
) (
   input  logic                      clock,
   input  logic                      enable,
   input  logic signed [WIDTH-1:0]   mul_a,
   input  logic signed [WIDTH-1:0]   mul_b,
   output logic signed [2*WIDTH-1:0] product
);

   localparam int LO_W = (WIDTH + 1) / 2;
   localparam int HI_W = WIDTH - LO_W;
   localparam int PW   = 2 * WIDTH;

   logic signed [HI_W-1:0]     a_hi, b_hi;
   logic signed [LO_W:0]       a_lo_s, b_lo_s;
   logic [LO_W-1:0]            a_lo, b_lo;

   logic signed [2*HI_W-1:0]   hh_in, hh_ff;
   logic signed [WIDTH:0]      hl_in, hl_ff;
   logic signed [WIDTH:0]      lh_in, lh_ff;
   logic [2*LO_W-1:0]          ll_in, ll_ff;
   logic [PW-1:0]              product_in, product_ff;

   assign a_hi   = $signed(mul_a[WIDTH-1:LO_W]);
   assign b_hi   = $signed(mul_b[WIDTH-1:LO_W]);
   assign a_lo   = mul_a[LO_W-1:0];
   assign b_lo   = mul_b[LO_W-1:0];
   assign a_lo_s = $signed({1'b0, a_lo});
   assign b_lo_s = $signed({1'b0, b_lo});

   assign hh_in = a_hi * b_hi;
   assign hl_in = a_hi * b_lo_s;
   assign lh_in = a_lo_s * b_hi;
   assign ll_in = a_lo * b_lo;

   always_ff @(posedge clock) begin
      if (enable) begin
         hh_ff <= hh_in;
         hl_ff <= hl_in;
         lh_ff <= lh_in;
         ll_ff <= ll_in;
      end
   end

   // The true product fits in PW bits, so the sum is taken modulo 2**PW.
   assign product_in = ({{(PW-2*HI_W){hh_ff[2*HI_W-1]}}, hh_ff} << (2*LO_W))
                     + ({{(PW-WIDTH-1){hl_ff[WIDTH]}}, hl_ff} << LO_W)
                     + ({{(PW-WIDTH-1){lh_ff[WIDTH]}}, lh_ff} << LO_W)
                     + {{(PW-2*LO_W){1'b0}}, ll_ff};

   always_ff @(posedge clock) begin
      if (enable) begin
         product_ff <= product_in;
      end
   end

   assign product = $signed(product_ff);

endmodule
